### hdl/ctdr_pkg.sv
package ctdr_pkg;

  // Color kind codes, shared by input and result items
  localparam logic [1:0] KindDefault = 2'd0;
  localparam logic [1:0] KindRgb     = 2'd1;
  localparam logic [1:0] KindIndexed = 2'd2;

  // Color depth codes of the configuration register
  localparam logic [1:0] DepthTrue   = 2'd0;
  localparam logic [1:0] Depth256    = 2'd1;
  localparam logic [1:0] Depth16     = 2'd2;

  localparam logic [1:0] DepthReset  = DepthTrue;

  // Palette regions
  localparam logic [7:0] CubeFirst   = 8'd16;
  localparam logic [7:0] GrayFirst   = 8'd232;

  // Channel threshold for the sixteen-color map
  localparam logic [7:0] HalfLevel   = 8'd127;

  typedef struct packed {
    logic [1:0] color_kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] palette_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_index;
  } out_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage

### hdl/ctdr_palette.sv
module ctdr_palette (
  input  logic [7:0]   index_i,
  output ctdr_pkg::rgb_t rgb_o
);

  // Channel levels of the 6x6x6 cube
  function automatic logic [7:0] cube_level(input logic [2:0] step);
    logic [7:0] lvl;
    begin
      case (step)
        3'd0:    lvl = 8'd0;
        3'd1:    lvl = 8'd95;
        3'd2:    lvl = 8'd135;
        3'd3:    lvl = 8'd175;
        3'd4:    lvl = 8'd215;
        default: lvl = 8'd255;
      endcase
      return lvl;
    end
  endfunction

  logic [7:0] base_lvl;
  logic [7:0] cube_off;
  logic [2:0] cube_r;
  logic [2:0] cube_g;
  logic [7:0] rem_r;
  logic [7:0] rem_g;
  logic [7:0] gray_lvl;

  // Split the cube offset into its three base-6 digits by comparison
  always_comb begin
    cube_off = index_i - ctdr_pkg::CubeFirst;
    cube_r   = 3'd0;
    for (int k = 1; k < 6; k++) begin
      if (cube_off >= 8'(36 * k)) cube_r = 3'(k);
    end
    rem_r  = cube_off - 8'(36 * cube_r);
    cube_g = 3'd0;
    for (int k = 1; k < 6; k++) begin
      if (rem_r >= 8'(6 * k)) cube_g = 3'(k);
    end
    rem_g = rem_r - 8'(6 * cube_g);
  end

  assign base_lvl = index_i[3] ? 8'd255 : 8'd128;
  assign gray_lvl = 8'(8 + 10 * (index_i - ctdr_pkg::GrayFirst));

  // Pick the palette region
  always_comb begin
    if (index_i < ctdr_pkg::CubeFirst) begin
      rgb_o.red   = index_i[0] ? base_lvl : 8'd0;
      rgb_o.green = index_i[1] ? base_lvl : 8'd0;
      rgb_o.blue  = index_i[2] ? base_lvl : 8'd0;
    end else if (index_i < ctdr_pkg::GrayFirst) begin
      rgb_o.red   = cube_level(cube_r);
      rgb_o.green = cube_level(cube_g);
      rgb_o.blue  = cube_level(rem_g[2:0]);
    end else begin
      rgb_o.red   = gray_lvl;
      rgb_o.green = gray_lvl;
      rgb_o.blue  = gray_lvl;
    end
  end

endmodule

### hdl/ctdr_reduce.sv
module ctdr_reduce (
  input  ctdr_pkg::in_item_t  item_i,
  input  logic [1:0]          depth_i,
  output ctdr_pkg::out_item_t result_o
);

  // Channel to cube step: v * 5 / 255, i.e. the count of multiples of 51 reached
  function automatic logic [2:0] cube_step(input logic [7:0] v);
    logic [2:0] s;
    begin
      s = 3'd0;
      for (int k = 1; k < 6; k++) begin
        if (v >= 8'(51 * k)) s = 3'(k);
      end
      return s;
    end
  endfunction

  ctdr_pkg::rgb_t pal_rgb;
  ctdr_pkg::rgb_t src_rgb;
  logic           pass;
  logic [2:0]     step_r;
  logic [2:0]     step_g;
  logic [2:0]     step_b;
  logic [7:0]     idx_256;
  logic [7:0]     idx_16;

  ctdr_palette u_palette (
    .index_i (item_i.palette_index),
    .rgb_o   (pal_rgb)
  );

  assign pass = (item_i.color_kind == ctdr_pkg::KindDefault) ||
                (depth_i == ctdr_pkg::DepthTrue) ||
                (depth_i == ctdr_pkg::Depth256 &&
                 item_i.color_kind == ctdr_pkg::KindIndexed);

  // Indexed input goes through the palette, anything else counts as RGB
  always_comb begin
    if (item_i.color_kind == ctdr_pkg::KindIndexed) begin
      src_rgb = pal_rgb;
    end else begin
      src_rgb.red   = item_i.red;
      src_rgb.green = item_i.green;
      src_rgb.blue  = item_i.blue;
    end
  end

  assign step_r  = cube_step(src_rgb.red);
  assign step_g  = cube_step(src_rgb.green);
  assign step_b  = cube_step(src_rgb.blue);
  assign idx_256 = 8'(16 + 36 * step_r + 6 * step_g + step_b);
  assign idx_16  = {5'd0,
                    src_rgb.blue  > ctdr_pkg::HalfLevel,
                    src_rgb.green > ctdr_pkg::HalfLevel,
                    src_rgb.red   > ctdr_pkg::HalfLevel};

  // Pass through unchanged or emit a newly indexed color
  always_comb begin
    if (pass) begin
      result_o.out_kind  = item_i.color_kind;
      result_o.out_red   = item_i.red;
      result_o.out_green = item_i.green;
      result_o.out_blue  = item_i.blue;
      result_o.out_index = item_i.palette_index;
    end else begin
      result_o.out_kind  = ctdr_pkg::KindIndexed;
      result_o.out_red   = 8'd0;
      result_o.out_green = 8'd0;
      result_o.out_blue  = 8'd0;
      result_o.out_index = (depth_i == ctdr_pkg::Depth256) ? idx_256 : idx_16;
    end
  end

endmodule

### hdl/terminal_color_depth_reducer_unit.sv
// Terminal color depth reducer.
// Input channel: in_item_i qualified by in_valid_i; a transfer happens on a
// rising edge with in_valid_i high and in_stall_o low. Output channel:
// out_item_o qualified by out_valid_o; a transfer happens with out_valid_o
// high and out_stall_i low.
// Configuration: cfg_data_i sets the color depth (true color, 256, 16) on an
// edge with cfg_valid_i high; cfg_ready_o is always high. Change it only
// while no item is in flight.
// Each item passes the input register and then the result register before
// it is shown on out_item_o. Throughput: one item per cycle while the
// receiver does not stall; the input register and the result register each
// hold one item and the conversion between them is short combinational logic.
// When the receiver stalls, the result stays put and the input register still
// takes one more item; in_stall_o rises only when both registers are full.
// Reset clears both valid flags and sets the depth to true color.
module terminal_color_depth_reducer_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ctdr_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ctdr_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_data_i
);

  logic                in_valid_q;
  ctdr_pkg::in_item_t  in_item_q;
  logic                res_valid_q;
  ctdr_pkg::out_item_t res_q;
  ctdr_pkg::out_item_t res_d;
  logic [1:0]          depth_q;
  logic                in_adv;
  logic                res_adv;

  assign res_adv     = !res_valid_q || !out_stall_i;
  assign in_adv      = !in_valid_q || res_adv;
  assign in_stall_o  = !in_adv;
  assign cfg_ready_o = 1'b1;

  // Depth register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= ctdr_pkg::DepthReset;
    end else if (cfg_valid_i) begin
      depth_q <= cfg_data_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_adv) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && in_valid_i) begin
      in_item_q <= in_item_i;
    end
  end

  ctdr_reduce u_reduce (
    .item_i   (in_item_q),
    .depth_i  (depth_q),
    .result_o (res_d)
  );

  // Result register, held while the receiver stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_adv) begin
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_adv && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_item_o  = res_q;

endmodule

### hdl/ctdr_checker.sv
module ctdr_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input ctdr_pkg::out_item_t out_item_o
);

  // Nothing leaves while reset is held
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result shown during reset");

  // Input stalls only when the result register is full and blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // An accepted item reaches the output if the result register then advances
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted item did not reach the output");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled result changed");

endmodule

bind terminal_color_depth_reducer_unit ctdr_checker u_ctdr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  // Codes that the package leaves unnamed: both fields are two bits wide
  localparam logic [1:0] KindSpare  = 2'd3;
  localparam logic [1:0] DepthSpare = 2'd3;

  // How a directed row gets its expected result
  localparam int RowPredict = 0;
  localparam int RowPass    = 1;
  localparam int RowIndex   = 2;

  localparam int CycleLimit  = 200000;
  localparam int HoldCycles  = 120;
  localparam int PhaseCount  = 8;
  localparam int PhaseItems  = 212;

  typedef struct {
    logic [1:0]         depth;
    ctdr_pkg::in_item_t item;
    int                 how;
    int                 want_index;
  } probe_t;

  logic                clk;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  ctdr_pkg::in_item_t  in_item_i;
  logic                out_valid_o;
  logic                out_stall_i;
  ctdr_pkg::out_item_t out_item_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [1:0]          cfg_data_i;

  ctdr_pkg::out_item_t pending_colors [$];
  ctdr_pkg::out_item_t oldest_color;
  probe_t      probe_rows [$];
  logic [1:0]  depth_now;
  bit          offering;
  bit          quiet;
  bit          hold_tick;
  bit          hold_seen;
  int unsigned stall_span;
  int unsigned cycle_count;
  int          mismatch_count;

  terminal_color_depth_reducer_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Level of one step of the 6x6x6 cube
  function automatic int cube_level(int step);
    case (step)
      0: return 0;
      1: return 95;
      2: return 135;
      3: return 175;
      4: return 215;
      default: return 255;
    endcase
  endfunction

  // Reduce one color to the given depth
  function automatic ctdr_pkg::out_item_t reduce_color(logic [1:0] depth,
                                                       ctdr_pkg::in_item_t it);
    ctdr_pkg::out_item_t res;
    int r, g, b, v, lvl, idx;
    res.out_kind  = it.color_kind;
    res.out_red   = it.red;
    res.out_green = it.green;
    res.out_blue  = it.blue;
    res.out_index = it.palette_index;
    if (it.color_kind == ctdr_pkg::KindDefault || depth == ctdr_pkg::DepthTrue ||
        (depth == ctdr_pkg::Depth256 && it.color_kind == ctdr_pkg::KindIndexed)) begin
      return res;
    end
    r = it.red;
    g = it.green;
    b = it.blue;
    // Expand a palette entry to its channels
    if (it.color_kind == ctdr_pkg::KindIndexed) begin
      v = it.palette_index;
      if (v < ctdr_pkg::CubeFirst) begin
        lvl = v[3] ? 255 : 128;
        r = v[0] ? lvl : 0;
        g = v[1] ? lvl : 0;
        b = v[2] ? lvl : 0;
      end else if (v < ctdr_pkg::GrayFirst) begin
        v = v - ctdr_pkg::CubeFirst;
        r = cube_level((v / 36) % 6);
        g = cube_level((v / 6) % 6);
        b = cube_level(v % 6);
      end else begin
        r = 8 + (v - ctdr_pkg::GrayFirst) * 10;
        g = r;
        b = r;
      end
    end
    if (depth == ctdr_pkg::Depth256) begin
      idx = ctdr_pkg::CubeFirst + 36 * (r * 5 / 255) + 6 * (g * 5 / 255) +
            (b * 5 / 255);
    end else begin
      idx = (r > ctdr_pkg::HalfLevel ? 1 : 0) | (g > ctdr_pkg::HalfLevel ? 2 : 0) |
            (b > ctdr_pkg::HalfLevel ? 4 : 0);
    end
    res.out_kind  = ctdr_pkg::KindIndexed;
    res.out_red   = '0;
    res.out_green = '0;
    res.out_blue  = '0;
    res.out_index = idx[7:0];
    return res;
  endfunction

  function automatic probe_t mk_row(logic [1:0] depth, logic [1:0] kind, logic [7:0] r,
                                    logic [7:0] g, logic [7:0] b, logic [7:0] idx,
                                    int how, int want_index);
    probe_t row;
    row.depth              = depth;
    row.item.color_kind    = kind;
    row.item.red           = r;
    row.item.green         = g;
    row.item.blue          = b;
    row.item.palette_index = idx;
    row.how                = how;
    row.want_index         = want_index;
    return row;
  endfunction

  // Channel values biased toward thresholds and cube step edges
  function automatic logic [7:0] random_level();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return ctdr_pkg::HalfLevel;
      3: return ctdr_pkg::HalfLevel + 8'd1;
      4: return 8'(51 * $urandom_range(1, 4) - $urandom_range(0, 1));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic ctdr_pkg::in_item_t random_color();
    ctdr_pkg::in_item_t it;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    it.color_kind = (pick == 0) ? ctdr_pkg::KindDefault : (pick < 5) ? ctdr_pkg::KindRgb :
                    (pick < 9) ? ctdr_pkg::KindIndexed : KindSpare;
    it.red   = random_level();
    it.green = random_level();
    it.blue  = random_level();
    pick = $urandom_range(0, 3);
    it.palette_index = (pick == 0) ? 8'($urandom_range(0, 15)) :
                       (pick == 1) ? 8'($urandom_range(232, 255)) :
                       8'($urandom_range(0, 255));
    return it;
  endfunction

  task automatic note_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Drop valid if an item is still on offer
  task automatic stop_offer();
    if (offering) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic drain_colors();
    while (pending_colors.size() != 0) @(posedge clk);
  endtask

  // Offer one item, hold it until the transfer, then maybe leave a gap
  task automatic offer_item(ctdr_pkg::in_item_t item, ctdr_pkg::out_item_t want,
                            bit gaps_ok);
    in_item_i <= item;
    if (!offering) begin
      in_valid_i <= 1'b1;
      offering = 1'b1;
    end
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    pending_colors.push_back(want);
    if (gaps_ok && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Change the depth once every result is out
  task automatic write_depth(logic [1:0] depth);
    stop_offer();
    drain_colors();
    repeat (4) @(posedge clk);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= depth;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    cfg_valid_i <= 1'b0;
    depth_now = depth;
  endtask

  // Receiver stalls in random bursts, calm windows, and a long hold on request
  always @(posedge clk) begin
    if (!rst_ni || quiet) begin
      out_stall_i <= 1'b0;
      stall_span  <= 0;
    end else if (hold_tick != hold_seen) begin
      hold_seen   <= hold_tick;
      out_stall_i <= 1'b1;
      stall_span  <= HoldCycles;
    end else if (stall_span != 0) begin
      stall_span <= stall_span - 1;
    end else begin
      out_stall_i <= (cycle_count[9:8] != 2'd0) && ($urandom_range(0, 2) == 0);
      stall_span  <= $urandom_range(0, 10);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_colors.size() == 0) begin
        note_mismatch("result with none pending, index", out_item_o.out_index, 8'd0);
      end else begin
        oldest_color = pending_colors.pop_front();
        if (out_item_o.out_kind !== oldest_color.out_kind)
          note_mismatch("out_kind", 8'(out_item_o.out_kind), 8'(oldest_color.out_kind));
        if (out_item_o.out_red !== oldest_color.out_red)
          note_mismatch("out_red", out_item_o.out_red, oldest_color.out_red);
        if (out_item_o.out_green !== oldest_color.out_green)
          note_mismatch("out_green", out_item_o.out_green, oldest_color.out_green);
        if (out_item_o.out_blue !== oldest_color.out_blue)
          note_mismatch("out_blue", out_item_o.out_blue, oldest_color.out_blue);
        if (out_item_o.out_index !== oldest_color.out_index)
          note_mismatch("out_index", out_item_o.out_index, oldest_color.out_index);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    ctdr_pkg::out_item_t want;
    ctdr_pkg::in_item_t  item;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_item_i      = '0;
    out_stall_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    offering       = 1'b0;
    quiet          = 1'b0;
    hold_tick      = 1'b0;
    hold_seen      = 1'b0;
    stall_span     = 0;
    cycle_count    = 0;
    mismatch_count = 0;
    depth_now      = ctdr_pkg::DepthReset;

    // True color after reset: everything passes
    probe_rows.push_back(mk_row(ctdr_pkg::DepthTrue, ctdr_pkg::KindDefault,
                                8'h00, 8'h00, 8'h00, 8'h00, RowPass, 0));
    probe_rows.push_back(mk_row(ctdr_pkg::DepthTrue, ctdr_pkg::KindRgb,
                                8'hff, 8'hff, 8'hff, 8'hff, RowPass, 0));
    probe_rows.push_back(mk_row(ctdr_pkg::DepthTrue, ctdr_pkg::KindIndexed,
                                8'h5a, 8'ha5, 8'h3c, 8'hff, RowPass, 0));
    probe_rows.push_back(mk_row(ctdr_pkg::DepthTrue, KindSpare,
                                8'haa, 8'h55, 8'hff, 8'h00, RowPass, 0));
    // 256 colors: indexed and default pass, RGB and the spare kind go to the cube
    probe_rows.push_back(mk_row(ctdr_pkg::Depth256, ctdr_pkg::KindDefault,
                                8'ha5, 8'h5a, 8'hff, 8'h0f, RowPass, 0));
    probe_rows.push_back(mk_row(ctdr_pkg::Depth256, ctdr_pkg::KindRgb,
                                8'h00, 8'h00, 8'h00, 8'hff, RowIndex, 16));
    probe_rows.push_back(mk_row(ctdr_pkg::Depth256, ctdr_pkg::KindRgb,
                                8'hff, 8'hff, 8'hff, 8'h00, RowIndex, 231));
    probe_rows.push_back(mk_row(ctdr_pkg::Depth256, ctdr_pkg::KindRgb,
                                8'd50, 8'd51, 8'd52, 8'h00, RowIndex, 23));
    probe_rows.push_back(mk_row(ctdr_pkg::Depth256, ctdr_pkg::KindIndexed,
                                8'd12, 8'd34, 8'd56, 8'd200, RowPass, 0));
    probe_rows.push_back(mk_row(ctdr_pkg::Depth256, KindSpare,
                                8'hff, 8'h00, 8'h00, 8'h00, RowIndex, 196));
    probe_rows.push_back(mk_row(ctdr_pkg::Depth256, ctdr_pkg::KindRgb,
                                8'd102, 8'd153, 8'd204, 8'h00, RowPredict, 0));
    // Sixteen colors: thresholds, base colors, cube and gray ramp edges
    probe_rows.push_back(mk_row(ctdr_pkg::Depth16, ctdr_pkg::KindRgb,
                                8'd128, 8'd127, 8'd255, 8'h00, RowIndex, 5));
    probe_rows.push_back(mk_row(ctdr_pkg::Depth16, ctdr_pkg::KindRgb,
                                8'd127, 8'd128, 8'd0, 8'hff, RowIndex, 2));
    probe_rows.push_back(mk_row(ctdr_pkg::Depth16, ctdr_pkg::KindIndexed,
                                8'hff, 8'hff, 8'hff, 8'd15, RowIndex, 7));
    probe_rows.push_back(mk_row(ctdr_pkg::Depth16, ctdr_pkg::KindIndexed,
                                8'hff, 8'hff, 8'hff, 8'd8, RowIndex, 0));
    probe_rows.push_back(mk_row(ctdr_pkg::Depth16, ctdr_pkg::KindIndexed,
                                8'h00, 8'h00, 8'h00, 8'd9, RowIndex, 1));
    probe_rows.push_back(mk_row(ctdr_pkg::Depth16, ctdr_pkg::KindIndexed,
                                8'hff, 8'hff, 8'hff, 8'd16, RowIndex, 0));
    probe_rows.push_back(mk_row(ctdr_pkg::Depth16, ctdr_pkg::KindIndexed,
                                8'h00, 8'h00, 8'h00, 8'd231, RowIndex, 7));
    probe_rows.push_back(mk_row(ctdr_pkg::Depth16, ctdr_pkg::KindIndexed,
                                8'hff, 8'hff, 8'hff, 8'd232, RowIndex, 0));
    probe_rows.push_back(mk_row(ctdr_pkg::Depth16, ctdr_pkg::KindIndexed,
                                8'h00, 8'h00, 8'h00, 8'd243, RowIndex, 0));
    probe_rows.push_back(mk_row(ctdr_pkg::Depth16, ctdr_pkg::KindIndexed,
                                8'h00, 8'h00, 8'h00, 8'd244, RowIndex, 7));
    probe_rows.push_back(mk_row(ctdr_pkg::Depth16, ctdr_pkg::KindIndexed,
                                8'h00, 8'h00, 8'h00, 8'd255, RowIndex, 7));
    probe_rows.push_back(mk_row(ctdr_pkg::Depth16, ctdr_pkg::KindDefault,
                                8'h81, 8'h42, 8'h24, 8'h18, RowPass, 0));
    probe_rows.push_back(mk_row(ctdr_pkg::Depth16, ctdr_pkg::KindIndexed,
                                8'h00, 8'h00, 8'h00, 8'd123, RowPredict, 0));
    // The spare depth behaves as sixteen colors
    probe_rows.push_back(mk_row(DepthSpare, KindSpare,
                                8'd200, 8'd0, 8'd0, 8'h00, RowIndex, 1));

    repeat (8) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Directed rows
    foreach (probe_rows[i]) begin
      if (probe_rows[i].depth != depth_now) write_depth(probe_rows[i].depth);
      item = probe_rows[i].item;
      if (probe_rows[i].how == RowPass) begin
        want.out_kind  = item.color_kind;
        want.out_red   = item.red;
        want.out_green = item.green;
        want.out_blue  = item.blue;
        want.out_index = item.palette_index;
      end else if (probe_rows[i].how == RowIndex) begin
        want.out_kind  = ctdr_pkg::KindIndexed;
        want.out_red   = '0;
        want.out_green = '0;
        want.out_blue  = '0;
        want.out_index = 8'(probe_rows[i].want_index);
      end else begin
        want = reduce_color(depth_now, item);
      end
      offer_item(item, want, 1'b1);
    end

    // Random phases, each at its own depth
    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0: write_depth(ctdr_pkg::Depth16);
        1: write_depth(ctdr_pkg::Depth256);
        2: write_depth(ctdr_pkg::DepthTrue);
        3: write_depth(DepthSpare);
        default: write_depth(2'($urandom_range(0, 3)));
      endcase
      for (int k = 0; k < PhaseItems; k++) begin
        if ((p == 2 || p == 5) && k == 50) hold_tick <= ~hold_tick;
        if (p == PhaseCount - 1 && k == 100) quiet <= 1'b1;
        item = random_color();
        offer_item(item, reduce_color(depth_now, item), !quiet && (k % 100 >= 25));
      end
    end

    stop_offer();
    drain_colors();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
